@@ src/owbm_pkg.sv @@
package owbm_pkg;

	localparam int unsigned BITS_PER_BYTE = 8;
	localparam int unsigned CFG_W         = 10;
	localparam int unsigned NUM_CFG       = 8;
	localparam int unsigned CFG_IDX_W     = 3;

	localparam logic [2:0] REQ_TICK  = 3'd0;
	localparam logic [2:0] REQ_RESET = 3'd1;
	localparam logic [2:0] REQ_WRITE = 3'd2;
	localparam logic [2:0] REQ_READ  = 3'd3;
	localparam logic [2:0] REQ_TOUCH = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_W0_LOW     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_W1_TAIL    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RD_SAMPLE  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RD_TAIL    = 3'd7;

	localparam logic [CFG_W-1:0] CFG_RESET_VAL [NUM_CFG] = '{
		10'd480, 10'd60, 10'd420, 10'd1, 10'd60, 10'd60, 10'd15, 10'd45
	};

	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_RESET = 3'd1,
		OP_WRITE = 3'd2,
		OP_READ  = 3'd3,
		OP_TOUCH = 3'd4
	} op_t;

	// One classified word as it travels from the front to the engine.
	typedef struct packed {
		logic       is_cmd;
		op_t        op;
		logic [7:0] tx;
		logic       line;
	} item_t;

endpackage

@@ src/one_wire_bus_master.sv @@
// One-wire bus master timed in ticks. Each input word is either a tick (req_type 0, or an
// unused code 5 to 7) that samples line_level and advances the slot timer by one, or a
// command (reset with presence sampling, write, read or touch of a byte sent LSB first)
// that starts an operation when idle and is flagged as rejected when busy. Every input word
// yields exactly one result word, in order, carrying the drive level to hold until the next
// tick, the busy flag, and on the finishing tick the done pulse with the presence result or
// the received byte. Slot lengths come from eight 10-bit registers written through the
// cfg port, which the user must write only while the block is idle; the block itself
// does not enforce this. A register value of 0 or 1 lasts one tick. Words enter a small
// queue and a phase sequencer retires one word per clock while the output is not stalled,
// so the block then sustains one word per cycle; each result waits in an output register.
module one_wire_bus_master import owbm_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [2:0]           req_type,
	input  logic [7:0]           tx_byte,
	input  logic                 line_level,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 drive_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 no_presence,
	output logic [7:0]           rx_byte,
	output logic                 rejected
);

	item_t push_item;
	item_t head;
	logic  push;
	logic  full;
	logic  pop;
	logic  not_empty;

	owbm_front u_front (
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.req_type   (req_type),
		.tx_byte    (tx_byte),
		.line_level (line_level),
		.q_full     (full),
		.q_push     (push),
		.q_item     (push_item)
	);

	owbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	owbm_engine u_engine (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.q_not_empty (not_empty),
		.q_head      (head),
		.q_pop       (pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.drive_low   (drive_low),
		.busy_res    (busy_res),
		.done_res    (done_res),
		.no_presence (no_presence),
		.rx_byte     (rx_byte),
		.rejected    (rejected)
	);

endmodule

@@ src/owbm_front.sv @@
module owbm_front import owbm_pkg::*; (
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] req_type,
	input  logic [7:0] tx_byte,
	input  logic       line_level,
	input  logic       q_full,
	output logic       q_push,
	output item_t      q_item
);

	assign in_ready = ~q_full;
	assign q_push   = in_valid & ~q_full;

	// Unused request codes are folded into plain ticks here.
	always_comb begin
		q_item.tx   = tx_byte;
		q_item.line = line_level;
		unique case (req_type)
			REQ_RESET: begin
				q_item.is_cmd = 1'b1;
				q_item.op     = OP_RESET;
			end
			REQ_WRITE: begin
				q_item.is_cmd = 1'b1;
				q_item.op     = OP_WRITE;
			end
			REQ_READ: begin
				q_item.is_cmd = 1'b1;
				q_item.op     = OP_READ;
			end
			REQ_TOUCH: begin
				q_item.is_cmd = 1'b1;
				q_item.op     = OP_TOUCH;
			end
			default: begin
				q_item.is_cmd = 1'b0;
				q_item.op     = OP_NONE;
			end
		endcase
	end

endmodule

@@ src/owbm_queue.sv @@
module owbm_queue import owbm_pkg::*; #(
	parameter int unsigned DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output logic  not_empty,
	output item_t head
);

	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	item_t            mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (count_q == FULL_CNT);
	assign not_empty = (count_q != '0);
	assign head      = mem_q[rd_ptr_q];
	assign do_push   = push & ~full;
	assign do_pop    = pop & not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

@@ src/owbm_engine.sv @@
module owbm_engine import owbm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic                 q_not_empty,
	input  item_t                q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 drive_low,
	output logic                 busy_res,
	output logic                 done_res,
	output logic                 no_presence,
	output logic [7:0]           rx_byte,
	output logic                 rejected
);

	typedef enum logic [3:0] {
		PH_IDLE, PH_RLOW, PH_RWAIT, PH_RTAIL, PH_W1LOW, PH_W1TAIL,
		PH_W0LOW, PH_W0REC, PH_RDLOW, PH_RDWAIT, PH_RDTAIL
	} phase_t;

	logic [CFG_W-1:0] cfg_q [NUM_CFG];

	phase_t           phase_q, n_phase;
	op_t              op_q, n_op;
	logic [CFG_W-1:0] timer_q, n_timer;
	logic [2:0]       bit_q, n_bit;
	logic [7:0]       tx_q, n_tx;
	logic [7:0]       rx_q, n_rx;
	logic             pres_q, n_pres;

	logic             out_valid_q;
	logic             drive_q, busy_q, done_q, nopres_q, rej_q;
	logic [7:0]       rxo_q;

	logic             n_done, n_rej, n_nopres;
	logic [7:0]       n_rxo;
	logic             step;

	// Picks the first phase of a bit slot from the operation and the bit to send.
	function automatic phase_t slot_phase(op_t op, logic b);
		phase_t ph;
		if (op == OP_READ || (op == OP_TOUCH && b)) begin
			ph = PH_RDLOW;
		end else if (b) begin
			ph = PH_W1LOW;
		end else begin
			ph = PH_W0LOW;
		end
		return ph;
	endfunction

	function automatic logic is_low(phase_t ph);
		return (ph == PH_RLOW) || (ph == PH_W1LOW) || (ph == PH_W0LOW) || (ph == PH_RDLOW);
	endfunction

	assign step  = q_not_empty & (~out_valid_q | out_ready);
	assign q_pop = step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				cfg_q[i] <= CFG_RESET_VAL[i];
			end
		end else if (cfg_we) begin
			cfg_q[cfg_idx] <= cfg_wdata;
		end
	end

	always_comb begin
		n_phase  = phase_q;
		n_op     = op_q;
		n_timer  = timer_q;
		n_bit    = bit_q;
		n_tx     = tx_q;
		n_rx     = rx_q;
		n_pres   = pres_q;
		n_done   = 1'b0;
		n_rej    = 1'b0;
		n_nopres = 1'b0;
		n_rxo    = '0;

		if (q_head.is_cmd) begin
			if (phase_q != PH_IDLE) begin
				n_rej = 1'b1;
			end else begin
				n_op  = q_head.op;
				n_bit = '0;
				n_tx  = q_head.tx;
				n_rx  = '0;
				if (q_head.op == OP_RESET) begin
					n_pres  = 1'b0;
					n_phase = PH_RLOW;
					n_timer = cfg_q[CFG_RESET_LOW];
				end else begin
					n_phase = slot_phase(q_head.op, q_head.tx[0]);
					n_timer = (n_phase == PH_W0LOW) ? cfg_q[CFG_W0_LOW] : cfg_q[CFG_SHORT_LOW];
				end
			end
		end else if (phase_q != PH_IDLE) begin
			if (timer_q > CFG_W'(1)) begin
				n_timer = timer_q - CFG_W'(1);
			end else begin
				unique case (phase_q)
					PH_RLOW: begin
						n_phase = PH_RWAIT;
						n_timer = cfg_q[CFG_PRES_WAIT];
					end
					PH_RWAIT: begin
						n_pres  = q_head.line;
						n_phase = PH_RTAIL;
						n_timer = cfg_q[CFG_RESET_TAIL];
					end
					PH_RTAIL: begin
						n_phase  = PH_IDLE;
						n_timer  = '0;
						n_done   = 1'b1;
						n_nopres = pres_q;
					end
					PH_W1LOW: begin
						n_phase = PH_W1TAIL;
						n_timer = cfg_q[CFG_W1_TAIL];
					end
					PH_W0LOW: begin
						n_phase = PH_W0REC;
						n_timer = cfg_q[CFG_SHORT_LOW];
					end
					PH_RDLOW: begin
						n_phase = PH_RDWAIT;
						n_timer = cfg_q[CFG_RD_SAMPLE];
					end
					PH_RDWAIT: begin
						if (q_head.line) begin
							n_rx = rx_q | 8'h80;
						end
						n_phase = PH_RDTAIL;
						n_timer = cfg_q[CFG_RD_TAIL];
					end
					PH_W1TAIL, PH_W0REC, PH_RDTAIL: begin
						// End of a bit slot: finish the byte or start the next slot.
						n_tx = tx_q >> 1;
						if (bit_q == 3'(BITS_PER_BYTE - 1)) begin
							n_phase = PH_IDLE;
							n_timer = '0;
							n_done  = 1'b1;
							if (op_q == OP_READ || op_q == OP_TOUCH) begin
								n_rxo = rx_q;
							end
						end else begin
							n_bit = bit_q + 3'd1;
							if (op_q == OP_READ || op_q == OP_TOUCH) begin
								n_rx = rx_q >> 1;
							end
							n_phase = slot_phase(op_q, n_tx[0]);
							n_timer = (n_phase == PH_W0LOW) ? cfg_q[CFG_W0_LOW]
							                                : cfg_q[CFG_SHORT_LOW];
						end
					end
					default: begin
						n_phase = PH_IDLE;
						n_timer = '0;
					end
				endcase
			end
		end

		if (q_head.is_cmd && phase_q == PH_IDLE && q_head.op != OP_RESET &&
		    (q_head.op == OP_READ || q_head.op == OP_TOUCH)) begin
			n_rx = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			op_q        <= OP_NONE;
			timer_q     <= '0;
			bit_q       <= '0;
			tx_q        <= '0;
			rx_q        <= '0;
			pres_q      <= 1'b0;
			out_valid_q <= 1'b0;
			drive_q     <= 1'b0;
			busy_q      <= 1'b0;
			done_q      <= 1'b0;
			nopres_q    <= 1'b0;
			rej_q       <= 1'b0;
			rxo_q       <= '0;
		end else begin
			if (step) begin
				phase_q     <= n_phase;
				op_q        <= n_op;
				timer_q     <= n_timer;
				bit_q       <= n_bit;
				tx_q        <= n_tx;
				rx_q        <= n_rx;
				pres_q      <= n_pres;
				out_valid_q <= 1'b1;
				drive_q     <= is_low(n_phase);
				busy_q      <= (n_phase != PH_IDLE);
				done_q      <= n_done;
				nopres_q    <= n_nopres;
				rej_q       <= n_rej;
				rxo_q       <= n_rxo;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_low   = drive_q;
	assign busy_res    = busy_q;
	assign done_res    = done_q;
	assign no_presence = nopres_q;
	assign rx_byte     = rxo_q;
	assign rejected    = rej_q;

endmodule

@@ src/owbm_checker.sv @@
module owbm_checker import owbm_pkg::*; (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 cfg_we,
	input logic [CFG_IDX_W-1:0] cfg_idx,
	input logic [CFG_W-1:0]     cfg_wdata,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic [2:0]           req_type,
	input logic [7:0]           tx_byte,
	input logic                 line_level,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic                 drive_low,
	input logic                 busy_res,
	input logic                 done_res,
	input logic                 no_presence,
	input logic [7:0]           rx_byte,
	input logic                 rejected
);

	// A finishing word always leaves the bus released and the block idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && done_res |-> !busy_res && !drive_low && !rejected)
		else $error("done word with busy or driven bus");

	// A rejected command leaves the running operation untouched.
	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> busy_res && !done_res)
		else $error("rejected word while idle or finishing");

	// Driving the bus low only happens inside an operation.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && drive_low |-> busy_res)
		else $error("bus driven while idle");

	// Result fields are zero except on the finishing word.
	a_fields_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (no_presence || rx_byte != 8'h00) |-> done_res)
		else $error("result data without done");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive_low) && $stable(busy_res)
			&& $stable(done_res) && $stable(rx_byte) && $stable(rejected))
		else $error("stalled result word changed");

endmodule

bind one_wire_bus_master owbm_checker u_owbm_checker (.*);
